// ===== src/assert_macros.svh =====
// Assertion macros shared by the receive FIFO and the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Property checked on every rising edge of clk, off while rst_n is low.
`define URF_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("urf assertion failed");

// Same-cycle implication, checked on every rising edge of clk.
`define URF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("urf assertion failed");

`else

`define URF_ASSERT(lbl, prop)
`define URF_ASSERT_IMP(lbl, ante, cons)

`endif

`endif

// ===== src/urf_pkg.sv =====
// Shared types, codes and constants of the 8250 UART register file.
`timescale 1ns / 1ps

package urf_pkg;

    localparam int FifoDepth = 256;
    localparam int PtrW      = $clog2(FifoDepth);

    typedef logic [PtrW-1:0] ptr_t;

    typedef enum logic [1:0] {
        CMD_READ    = 2'd0,
        CMD_WRITE   = 2'd1,
        CMD_RX_BYTE = 2'd2,
        CMD_TICK    = 2'd3
    } cmd_t;

    // register offsets
    localparam logic [2:0] PORT_DATA = 3'd0;
    localparam logic [2:0] PORT_IER  = 3'd1;
    localparam logic [2:0] PORT_IIR  = 3'd2;
    localparam logic [2:0] PORT_LCR  = 3'd3;
    localparam logic [2:0] PORT_MCR  = 3'd4;
    localparam logic [2:0] PORT_LSR  = 3'd5;
    localparam logic [2:0] PORT_MSR  = 3'd6;
    localparam logic [2:0] PORT_SCR  = 3'd7;

    localparam int LCR_DLAB_BIT = 7;
    localparam int MCR_LOOP_BIT = 4;

    localparam logic [7:0] LSR_DR        = 8'h01;
    localparam logic [7:0] LSR_OE        = 8'h02;
    localparam logic [7:0] LSR_THRE      = 8'h20;
    localparam logic [7:0] LSR_TEMT      = 8'h40;
    localparam logic [7:0] LSR_READ_KEEP = 8'he1;
    localparam logic [7:0] LSR_RESET     = 8'h60;
    localparam logic [7:0] MSR_KEEP      = 8'hf0;
    localparam logic [7:0] IIR_RESET     = 8'h01;
    localparam logic [7:0] READ_IDLE     = 8'hff;

    typedef struct packed {
        logic       push;
        logic       pop;
        logic [7:0] wdata;
    } fifo_ctl_t;

    typedef struct packed {
        logic empty;
        logic full;
    } fifo_stat_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       rx_dropped;
    } result_t;

    function automatic ptr_t ring_next(ptr_t p);
        ring_next = (p == ptr_t'(FifoDepth - 1)) ? '0 : ptr_t'(p + 1'b1);
    endfunction

endpackage

// ===== src/urf_rx_fifo.sv =====
// Receive FIFO: ring memory with head/tail pointers and registered read (the RBR).
`timescale 1ns / 1ps
`include "assert_macros.svh"

module urf_rx_fifo (
    input  logic                   clk,
    input  logic                   rst_n,
    input  urf_pkg::fifo_ctl_t     ctl,
    output urf_pkg::fifo_stat_t    stat,
    output logic [7:0]             rx_buf
);
    import urf_pkg::*;

    logic [7:0] mem [FifoDepth];
    ptr_t       head_reg, head_next;
    ptr_t       tail_reg, tail_next;
    logic [7:0] rdata_reg;
    logic       wr_en, rd_en;

    assign stat.empty = (head_reg == tail_reg);
    assign stat.full  = (ring_next(head_reg) == tail_reg);

    assign wr_en = ctl.push && !stat.full;
    assign rd_en = ctl.pop && !stat.empty;

    always_comb
    begin
        head_next = wr_en ? ring_next(head_reg) : head_reg;
        tail_next = rd_en ? ring_next(tail_reg) : tail_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            rdata_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            if (rd_en)
            begin
                rdata_reg <= mem[tail_reg];
            end
        end
    end

    // only occupied entries are read, so head never collides with tail here
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[head_reg] <= ctl.wdata;
        end
    end

    assign rx_buf = rdata_reg;

    `URF_ASSERT(a_push_pop_exclusive, !(ctl.push && ctl.pop))
    `URF_ASSERT(a_drop_keeps_head, (ctl.push && stat.full) |=> (head_reg == $past(head_reg)))
    `URF_ASSERT(a_pop_moves_tail, (ctl.pop && !stat.empty) |=> (tail_reg != $past(tail_reg)))

endmodule

// ===== src/uart_8250_register_file_top.sv =====
// Top level of the 8250 UART register file with receive FIFO.
// An accepted word's result is registered in the output register, or in the skid entry while the output is held.
// Throughput: one word per cycle while in_stall is low; the FIFO memory sees at most one access per word.
// A two-entry output stage (register plus skid) keeps input stall registered.
// Reset (rst_n low, async): registers to 8250 defaults, FIFO empty, no results.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module uart_8250_register_file_top (
    input  logic       clk,
    input  logic       rst_n,
    // config channel
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data,
    // input channel
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [1:0] cmd,
    input  logic [2:0] port,
    input  logic [7:0] data,
    // output channel
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] read_data,
    output logic       tx_valid,
    output logic [7:0] tx_byte,
    output logic       rx_dropped
);
    import urf_pkg::*;

    // config and register state
    logic       tx_link_reg;
    logic [7:0] dll_reg, dll_next;
    logic [7:0] dlm_reg, dlm_next;
    logic [7:0] ier_reg, ier_next;
    logic [7:0] lcr_reg, lcr_next;
    logic [7:0] mcr_reg, mcr_next;
    logic [7:0] lsr_reg, lsr_next;
    logic [7:0] msr_reg, msr_next;
    logic [7:0] scr_reg, scr_next;

    // output stage
    logic    out_valid_reg, out_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t out_data_reg, out_data_next;
    result_t skid_data_reg, skid_data_next;

    fifo_ctl_t  fifo_ctl;
    fifo_stat_t fifo_stat;
    logic [7:0] rx_buf;

    logic       accept;
    logic       out_take;
    cmd_t       cmd_c;
    logic       dlab;
    logic [7:0] loop_m;
    logic [7:0] msr_eff;
    logic [7:0] lsr_rd;
    result_t    res;

    assign cfg_ready = 1'b1;
    assign in_stall  = skid_valid_reg;
    assign accept    = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;
    assign cmd_c     = cmd_t'(cmd);
    assign dlab      = lcr_reg[LCR_DLAB_BIT];

    // modem status as seen by a read, loopback applied
    assign loop_m  = {mcr_reg[3:0], 4'b0000};
    assign msr_eff = mcr_reg[MCR_LOOP_BIT] ? (((msr_reg ^ loop_m) >> 4) | loop_m) : msr_reg;
    assign lsr_rd  = lsr_reg | LSR_THRE;

    assign fifo_ctl.push  = accept && (cmd_c == CMD_RX_BYTE);
    assign fifo_ctl.pop   = accept && (cmd_c == CMD_TICK);
    assign fifo_ctl.wdata = data;

    urf_rx_fifo u_rx_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (fifo_ctl),
        .stat   (fifo_stat),
        .rx_buf (rx_buf)
    );

    // register update and result for the word at the input
    always_comb
    begin
        dll_next = dll_reg;
        dlm_next = dlm_reg;
        ier_next = ier_reg;
        lcr_next = lcr_reg;
        mcr_next = mcr_reg;
        lsr_next = lsr_reg;
        msr_next = msr_reg;
        scr_next = scr_reg;

        res.read_data  = READ_IDLE;
        res.tx_valid   = 1'b0;
        res.tx_byte    = 8'h00;
        res.rx_dropped = 1'b0;

        case (cmd_c)
            CMD_READ:
            begin
                case (port)
                    PORT_DATA:
                    begin
                        if (dlab)
                        begin
                            res.read_data = dll_reg;
                        end
                        else
                        begin
                            res.read_data = rx_buf;
                            lsr_next      = lsr_reg & ~LSR_DR;
                        end
                    end
                    PORT_IER: res.read_data = dlab ? dlm_reg : ier_reg;
                    PORT_IIR: res.read_data = IIR_RESET;
                    PORT_LCR: res.read_data = lcr_reg;
                    PORT_MCR: res.read_data = mcr_reg;
                    PORT_LSR:
                    begin
                        res.read_data = lsr_rd;
                        lsr_next      = lsr_rd & LSR_READ_KEEP;
                    end
                    PORT_MSR:
                    begin
                        res.read_data = msr_eff;
                        msr_next      = msr_eff & MSR_KEEP;
                    end
                    default: res.read_data = scr_reg;
                endcase
            end
            CMD_WRITE:
            begin
                case (port)
                    PORT_DATA:
                    begin
                        if (dlab)
                        begin
                            dll_next = data;
                        end
                        else
                        begin
                            res.tx_valid = 1'b1;
                            res.tx_byte  = data;
                            if (tx_link_reg)
                            begin
                                lsr_next = lsr_reg & ~LSR_TEMT;
                            end
                        end
                    end
                    PORT_IER:
                    begin
                        if (dlab)
                        begin
                            dlm_next = data;
                        end
                        else
                        begin
                            ier_next = data;
                        end
                    end
                    PORT_LCR: lcr_next = data;
                    PORT_MCR: mcr_next = data;
                    PORT_SCR: scr_next = data;
                    default: ;  // IIR, LSR, MSR are read-only
                endcase
            end
            CMD_RX_BYTE:
            begin
                res.rx_dropped = fifo_stat.full;
            end
            CMD_TICK:
            begin
                // FIFO moves its oldest byte into the RBR read register
                if (!fifo_stat.empty)
                begin
                    lsr_next = lsr_reg | LSR_DR | (lsr_reg[0] ? LSR_OE : 8'h00);
                end
            end
            default: ;
        endcase
    end

    // output register with skid entry
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (out_take)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        if (accept)
        begin
            if (out_valid_reg && !out_take)
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = res;
            end
            else
            begin
                out_valid_next = 1'b1;
                out_data_next  = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tx_link_reg    <= 1'b0;
            dll_reg        <= '0;
            dlm_reg        <= '0;
            ier_reg        <= '0;
            lcr_reg        <= '0;
            mcr_reg        <= '0;
            lsr_reg        <= LSR_RESET;
            msr_reg        <= '0;
            scr_reg        <= '0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                tx_link_reg <= cfg_data;
            end
            if (accept)
            begin
                dll_reg <= dll_next;
                dlm_reg <= dlm_next;
                ier_reg <= ier_next;
                lcr_reg <= lcr_next;
                mcr_reg <= mcr_next;
                lsr_reg <= lsr_next;
                msr_reg <= msr_next;
                scr_reg <= scr_next;
            end
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // result payload needs no reset
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid  = out_valid_reg;
    assign read_data  = out_data_reg.read_data;
    assign tx_valid   = out_data_reg.tx_valid;
    assign tx_byte    = out_data_reg.tx_byte;
    assign rx_dropped = out_data_reg.rx_dropped;

    `URF_ASSERT_IMP(a_skid_needs_out, skid_valid_reg, out_valid_reg)
    `URF_ASSERT_IMP(a_tx_not_read, out_valid_reg && out_data_reg.tx_valid, out_data_reg.read_data == READ_IDLE)
    `URF_ASSERT(a_tick_overrun, (accept && cmd_c == CMD_TICK && !fifo_stat.empty && lsr_reg[0]) |=> lsr_reg[1])

endmodule

// ===== tb/sv/tb_uart_8250_register_file_top.sv =====
// Self-checking testbench for the 8250 UART register file top level.
`timescale 1ns / 1ps

module tb_uart_8250_register_file_top;
    import urf_pkg::*;

    // One bus word as the sender offers it.
    typedef struct packed {
        cmd_t       op;
        logic [2:0] p;
        logic [7:0] d;
    } uart_word_t;

    localparam int QuietLimit = 4000;   // cycles with no handshake before giving up
    localparam int HoldCycles = 80;     // long receiver hold-off in the pressure phase

    logic       clk;
    logic       rst_n = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_data = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [1:0] cmd = 2'd0;
    logic [2:0] port = 3'd0;
    logic [7:0] data = 8'd0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] read_data;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       rx_dropped;

    uart_8250_register_file_top DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .port       (port),
        .data       (data),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .read_data  (read_data),
        .tx_valid   (tx_valid),
        .tx_byte    (tx_byte),
        .rx_dropped (rx_dropped)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the register file. Updated once per accepted word,
    // in acceptance order, so it always mirrors what the block should hold.
    // ------------------------------------------------------------------
    logic       link_cfg;
    logic [7:0] rbr, dll, dlm, ier, iir, lcr, mcr, lsr, msr, scr;
    logic [7:0] rx_mem [FifoDepth];
    ptr_t       rx_head, rx_tail;

    // Words waiting to be offered, and responses still owed by the block.
    uart_word_t bus_word_q[$];
    result_t    resp_q[$];

    int err_cnt = 0;
    int quiet_cycles = 0;

    // Pacing knobs, changed only between phases.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic hold_arm = 1'b0;

    // Receiver-side hold-off bookkeeping, owned by the stall process.
    int   hold_left = 0;
    logic hold_done = 1'b0;

    uart_word_t nxt;
    result_t    want;

    function automatic void regfile_reset();
        link_cfg = 1'b0;
        rbr = 8'h00; dll = 8'h00; dlm = 8'h00; ier = 8'h00;
        iir = IIR_RESET; lcr = 8'h00; mcr = 8'h00; lsr = LSR_RESET;
        msr = 8'h00; scr = 8'h00;
        rx_head = '0;
        rx_tail = '0;
    endfunction

    // Applies one word to the shadow registers and returns the response it owes.
    function automatic result_t regfile_apply(cmd_t op, logic [2:0] p, logic [7:0] d);
        result_t    r;
        logic       dlab;
        logic [7:0] m;
        ptr_t       nh;
        r.read_data  = READ_IDLE;
        r.tx_valid   = 1'b0;
        r.tx_byte    = 8'h00;
        r.rx_dropped = 1'b0;
        dlab = lcr[LCR_DLAB_BIT];
        case (op)
            CMD_READ:
            begin
                case (p)
                    PORT_DATA:
                    begin
                        if (dlab)
                            r.read_data = dll;
                        else
                        begin
                            r.read_data = rbr;
                            lsr = lsr & ~LSR_DR;
                        end
                    end
                    PORT_IER: r.read_data = dlab ? dlm : ier;
                    PORT_IIR: r.read_data = iir;
                    PORT_LCR: r.read_data = lcr;
                    PORT_MCR: r.read_data = mcr;
                    PORT_LSR:
                    begin
                        lsr = lsr | LSR_THRE;
                        r.read_data = lsr;
                        lsr = lsr & LSR_READ_KEEP;
                    end
                    PORT_MSR:
                    begin
                        // loopback folds modem control outputs into the status
                        if (mcr[MCR_LOOP_BIT])
                        begin
                            m = {mcr[3:0], 4'h0};
                            msr = ((msr ^ m) >> 4) | m;
                        end
                        r.read_data = msr;
                        msr = msr & MSR_KEEP;
                    end
                    default: r.read_data = scr;
                endcase
            end
            CMD_WRITE:
            begin
                case (p)
                    PORT_DATA:
                    begin
                        if (dlab)
                            dll = d;
                        else
                        begin
                            r.tx_valid = 1'b1;
                            r.tx_byte  = d;
                            if (link_cfg)
                                lsr = lsr & ~LSR_TEMT;
                        end
                    end
                    PORT_IER:
                    begin
                        if (dlab)
                            dlm = d;
                        else
                            ier = d;
                    end
                    PORT_LCR: lcr = d;
                    PORT_MCR: mcr = d;
                    PORT_SCR: scr = d;
                    default: ;
                endcase
            end
            CMD_RX_BYTE:
            begin
                // one slot stays free, so the queue holds depth-1 bytes
                nh = ptr_t'((int'(rx_head) + 1) % FifoDepth);
                if (nh != rx_tail)
                begin
                    rx_mem[rx_head] = d;
                    rx_head = nh;
                end
                else
                    r.rx_dropped = 1'b1;
            end
            default:
            begin
                if (rx_head != rx_tail)
                begin
                    rbr = rx_mem[rx_tail];
                    rx_tail = ptr_t'((int'(rx_tail) + 1) % FifoDepth);
                    if (lsr & LSR_DR)
                        lsr = lsr | LSR_OE;
                    lsr = lsr | LSR_DR;
                end
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int exp_v);
        $display("%0t: mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, exp_v);
        err_cnt++;
    endtask

    // ------------------------------------------------------------------
    // Sender: offers queued words, idling at random when the phase asks.
    // A stalled word holds still until it is taken.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || !in_stall)
        begin
            if (bus_word_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
            begin
                nxt = bus_word_q.pop_front();
                in_valid <= 1'b1;
                cmd      <= nxt.op;
                port     <= nxt.p;
                data     <= nxt.d;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stall, plus one long hold-off when armed so the
    // output stage fills and the block must stall its input.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_left != 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_arm && !hold_done)
        begin
            out_stall <= 1'b1;
            hold_left <= HoldCycles;
            hold_done <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // ------------------------------------------------------------------
    // Monitor: checks each taken response against the oldest owed one,
    // then records what the word taken at this edge should produce.
    // Also runs the no-progress watchdog.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (resp_q.size() == 0)
                    report_mismatch("response with none owed", read_data, 0);
                else
                begin
                    want = resp_q.pop_front();
                    if (read_data !== want.read_data)
                        report_mismatch("read_data", read_data, want.read_data);
                    if (tx_valid !== want.tx_valid)
                        report_mismatch("tx_valid", tx_valid, want.tx_valid);
                    if (tx_byte !== want.tx_byte)
                        report_mismatch("tx_byte", tx_byte, want.tx_byte);
                    if (rx_dropped !== want.rx_dropped)
                        report_mismatch("rx_dropped", rx_dropped, want.rx_dropped);
                end
            end
            if (in_valid && !in_stall)
                resp_q.push_back(regfile_apply(cmd_t'(cmd), port, data));

            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= QuietLimit)
            begin
                $display("%0t: no progress for %0d cycles", $time, QuietLimit);
                $display("FAIL uart_8250_register_file_top");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void add_word(cmd_t op, logic [2:0] p, logic [7:0] d);
        uart_word_t w;
        w.op = op;
        w.p  = p;
        w.d  = d;
        bus_word_q.push_back(w);
    endfunction

    function automatic logic [7:0] rnd_byte();
        return 8'($urandom_range(255));
    endfunction

    // Waits until every word went in and every response came back.
    task automatic wait_drained();
        while (bus_word_q.size() != 0 || in_valid || resp_q.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // Writes the transmit-link register; only called with the block idle.
    task automatic set_link(logic v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        link_cfg = v;
    endtask

    // Mostly well-formed register sequences with random content, some noise.
    task automatic run_random(int n_words);
        int start;
        int k;
        int j;
        logic [7:0] v;
        start = bus_word_q.size();
        while (bus_word_q.size() - start < n_words)
        begin
            case ($urandom_range(9))
                0, 1:
                begin
                    // receive burst, then drain some of it
                    k = $urandom_range(1, 6);
                    for (j = 0; j < k; j++)
                        add_word(CMD_RX_BYTE, PORT_DATA, rnd_byte());
                    k = $urandom_range(0, k + 1);
                    for (j = 0; j < k; j++)
                    begin
                        add_word(CMD_TICK, 3'($urandom_range(7)), rnd_byte());
                        if ($urandom_range(1))
                            add_word(CMD_READ, PORT_DATA, rnd_byte());
                    end
                    add_word(CMD_READ, PORT_LSR, rnd_byte());
                end
                2:
                begin
                    // divisor latch access
                    v = rnd_byte();
                    add_word(CMD_WRITE, PORT_LCR, v | 8'h80);
                    add_word(CMD_WRITE, PORT_DATA, rnd_byte());
                    add_word(CMD_WRITE, PORT_IER, rnd_byte());
                    add_word(CMD_READ, PORT_DATA, rnd_byte());
                    add_word(CMD_READ, PORT_IER, rnd_byte());
                    add_word(CMD_WRITE, PORT_LCR, v & 8'h7f);
                end
                3:
                begin
                    // modem control, usually with loopback on
                    v = rnd_byte();
                    if ($urandom_range(3) != 0)
                        v[MCR_LOOP_BIT] = 1'b1;
                    add_word(CMD_WRITE, PORT_MCR, v);
                    add_word(CMD_READ, PORT_MSR, rnd_byte());
                    add_word(CMD_READ, PORT_MSR, rnd_byte());
                    add_word(CMD_READ, PORT_MCR, rnd_byte());
                end
                4:
                begin
                    k = $urandom_range(1, 4);
                    for (j = 0; j < k; j++)
                        add_word(CMD_WRITE, PORT_DATA, rnd_byte());
                    add_word(CMD_READ, PORT_LSR, rnd_byte());
                end
                5:
                begin
                    case ($urandom_range(2))
                        0: j = PORT_IER;
                        1: j = PORT_SCR;
                        default: j = PORT_LCR;
                    endcase
                    v = rnd_byte();
                    if (j == PORT_LCR)
                        v[LCR_DLAB_BIT] = 1'b0;
                    add_word(CMD_WRITE, 3'(j), v);
                    add_word(CMD_READ, 3'(j), rnd_byte());
                end
                6, 7: add_word(cmd_t'($urandom_range(3)), 3'($urandom_range(7)), rnd_byte());
                8: add_word(CMD_READ, 3'($urandom_range(7)), rnd_byte());
                default: add_word(CMD_TICK, PORT_DATA, rnd_byte());
            endcase
        end
    endtask

    // Overfills the receive queue so arriving bytes get dropped, then drains
    // it with ticks, reading data only now and then so overrun shows up.
    task automatic run_flood();
        int k;
        int j;
        k = FifoDepth + $urandom_range(2, 6);
        for (j = 0; j < k; j++)
            add_word(CMD_RX_BYTE, 3'($urandom_range(7)), rnd_byte());
        for (j = 0; j < FifoDepth + 2; j++)
        begin
            add_word(CMD_TICK, PORT_DATA, rnd_byte());
            if ($urandom_range(3) == 0)
                add_word(CMD_READ, PORT_DATA, rnd_byte());
            if ($urandom_range(15) == 0)
                add_word(CMD_READ, PORT_LSR, rnd_byte());
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        regfile_reset();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: divisor latches, transmit, read-only ports, receive
        // with overrun and empty tick, loopback, scratch.
        set_link(1'b1);
        add_word(CMD_WRITE, PORT_LCR, 8'h80);
        add_word(CMD_WRITE, PORT_DATA, 8'hff);
        add_word(CMD_WRITE, PORT_IER, 8'h5a);
        add_word(CMD_READ, PORT_DATA, 8'h00);
        add_word(CMD_READ, PORT_IER, 8'hff);
        add_word(CMD_WRITE, PORT_LCR, 8'h03);
        add_word(CMD_WRITE, PORT_DATA, 8'h00);
        add_word(CMD_WRITE, PORT_DATA, 8'hff);
        add_word(CMD_WRITE, PORT_IER, 8'hff);
        add_word(CMD_WRITE, PORT_IIR, 8'h55);
        add_word(CMD_WRITE, PORT_LSR, 8'haa);
        add_word(CMD_WRITE, PORT_MSR, 8'hff);
        add_word(CMD_RX_BYTE, PORT_DATA, 8'h00);
        add_word(CMD_RX_BYTE, PORT_SCR, 8'hff);
        add_word(CMD_TICK, PORT_DATA, 8'h00);
        add_word(CMD_TICK, PORT_DATA, 8'h00);
        add_word(CMD_TICK, PORT_SCR, 8'hff);
        add_word(CMD_READ, PORT_LSR, 8'h00);
        add_word(CMD_READ, PORT_DATA, 8'h00);
        add_word(CMD_WRITE, PORT_MCR, 8'h1f);
        add_word(CMD_READ, PORT_MSR, 8'h00);
        add_word(CMD_READ, PORT_MSR, 8'h00);
        add_word(CMD_WRITE, PORT_SCR, 8'ha5);
        add_word(CMD_READ, PORT_SCR, 8'h00);
        add_word(CMD_READ, PORT_IIR, 8'h00);
        wait_drained();

        // Back to back, no link.
        set_link(1'b0);
        run_random(350);
        wait_drained();

        // Sender idles; halfway it stops until every response is back.
        set_link(1'b1);
        send_idle_pct = 56;
        run_random(175);
        wait_drained();
        run_random(175);
        wait_drained();

        // Receiver stalls, with one long hold-off while the sender keeps
        // pushing; the receive queue is overfilled here too.
        set_link(1'b0);
        send_idle_pct = 0;
        recv_stall_pct = 56;
        hold_arm = 1'b1;
        run_flood();
        run_random(100);
        wait_drained();

        // Both sides idle now and then.
        set_link(1'b1);
        send_idle_pct = 27;
        recv_stall_pct = 27;
        run_random(350);
        wait_drained();

        repeat (8) @(posedge clk);
        if (err_cnt == 0)
            $display("PASS uart_8250_register_file_top");
        else
            $display("FAIL uart_8250_register_file_top");
        $finish;
    end

endmodule
